@@ rtl/triangle_closure_max_distance_core_assert.svh @@
// assertion macros shared by the triangle closure core
`ifndef TRIANGLE_CLOSURE_MAX_DISTANCE_CORE_ASSERT_SVH
`define TRIANGLE_CLOSURE_MAX_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tcmd_pkg.sv @@
// shared types and constants of the triangle closure core
package tcmd_pkg;

    localparam int MAX_NODES_DEFAULT   = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int DIST_WIDTH          = 32;
    localparam int STATUS_WIDTH        = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOT_TRI  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // which corner of the triangle gets lowered
    typedef enum logic [1:0] {
        SLOT_A,
        SLOT_B,
        SLOT_C
    } slot_t;

    typedef struct packed {
        logic  changed;
        slot_t slot;
    } relax_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ROW,
        ST_FIRST,
        ST_EXEC,
        ST_MAX,
        ST_DONE
    } state_t;

endpackage

@@ rtl/tcmd_store.sv @@
// distance store: one write port, two registered read ports
module tcmd_store #(
    parameter int DEPTH = 2016,
    parameter int AW    = 11,
    parameter int VW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic          re0,
    input  logic [AW-1:0] raddr0,
    output logic [VW-1:0] rdata0,
    input  logic          re1,
    input  logic [AW-1:0] raddr1,
    output logic [VW-1:0] rdata1
);

    logic [VW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re0)
        begin
            rdata0 <= mem[raddr0];
        end
        if (re1)
        begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

@@ rtl/tcmd_relax.sv @@
// one triangle update: lowers the largest of three entries to the middle one
module tcmd_relax #(
    parameter int VW = 32
) (
    input  logic [VW-1:0]        a,
    input  logic [VW-1:0]        b,
    input  logic [VW-1:0]        c,
    output tcmd_pkg::relax_ctl_t ctl,
    output logic [VW-1:0]        value
);

    logic [VW-1:0]   old_value;
    tcmd_pkg::slot_t slot;

    always_comb
    begin
        slot  = tcmd_pkg::SLOT_C;
        value = b;
        if (a <= b)
        begin
            if (b <= c)
            begin
                slot  = tcmd_pkg::SLOT_C;
                value = b;
            end
            else if (a < c)
            begin
                slot  = tcmd_pkg::SLOT_B;
                value = c;
            end
            else
            begin
                slot  = tcmd_pkg::SLOT_B;
                value = a;
            end
        end
        else
        begin
            if (b > c)
            begin
                slot  = tcmd_pkg::SLOT_A;
                value = b;
            end
            else if (a <= c)
            begin
                slot  = tcmd_pkg::SLOT_C;
                value = a;
            end
            else
            begin
                slot  = tcmd_pkg::SLOT_A;
                value = c;
            end
        end
    end

    always_comb
    begin
        unique case (slot)
            tcmd_pkg::SLOT_A: old_value = a;
            tcmd_pkg::SLOT_B: old_value = b;
            tcmd_pkg::SLOT_C: old_value = c;
            default:          old_value = c;
        endcase
    end

    assign ctl = {(old_value != value), slot};

endmodule

@@ rtl/triangle_closure_max_distance_core.sv @@
// Loading: one entry per cycle, the transfer carrying last closes the matrix.
// Closure: up to n-1 rounds; each round passes ST_ROUND and then, per row, ST_ROW and ST_FIRST
// and ST_EXEC for each triangle, a read-modify-write loop over the store's two read ports.
// Maximum: ST_MAX reads the store entry by entry, then ST_DONE hands off the result once the output is free.
// Error results (not triangular, overflow) skip closure and maximum: the last transfer leads straight to ST_DONE.
// Reset clears control and counters; the store itself is not cleared.
`include "triangle_closure_max_distance_core_assert.svh"

module triangle_closure_max_distance_core #(
    parameter int MAX_NODES   = tcmd_pkg::MAX_NODES_DEFAULT,
    parameter int VALUE_WIDTH = tcmd_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcmd_pkg::DIST_WIDTH-1:0]   distance,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcmd_pkg::DIST_WIDTH-1:0]   max_distance,
    output logic [tcmd_pkg::STATUS_WIDTH-1:0] status
);

    localparam int STORE_DEPTH = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(STORE_DEPTH + 1);
    localparam int NW          = $clog2(MAX_NODES + 1);
    localparam int VW          = VALUE_WIDTH;
    localparam int DW          = tcmd_pkg::DIST_WIDTH;

    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    // control
    tcmd_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [NW-1:0]     nodes_reg, nodes_next;
    logic [CW-1:0]     tri_reg, tri_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [AW-1:0]     row_reg, row_next;
    logic [AW-1:0]     next_row_reg, next_row_next;
    logic [NW-1:0]     len_reg, len_next;
    logic [NW-1:0]     round_reg, round_next;
    logic              changed_reg, changed_next;
    logic [AW-1:0]     b_addr_reg, b_addr_next;
    logic [AW-1:0]     c_addr_reg, c_addr_next;
    logic [VW-1:0]     a_reg, a_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              scan_vld_reg, scan_vld_next;
    logic [VW-1:0]     max_reg, max_next;
    tcmd_pkg::status_t code_reg, code_next;
    logic [DW-1:0]     max_distance_reg;
    tcmd_pkg::status_t status_reg;

    // store ports
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [VW-1:0]     wr_data;
    logic              rd0_en, rd1_en;
    logic [AW-1:0]     rd0_addr, rd1_addr;
    logic [VW-1:0]     q0, q1;

    tcmd_pkg::relax_ctl_t rctl;
    logic [VW-1:0]        rval;

    logic              in_accept;
    logic              result_load;
    logic              changed_any;
    logic [VW+DW-1:0]  in_wide;
    logic [VW+DW-1:0]  out_wide;
    logic [VW-1:0]     in_value;

    assign in_wide   = {{VW{1'b0}}, distance};
    assign in_value  = in_wide[VW-1:0];
    assign out_wide  = {{DW{1'b0}}, max_reg};

    assign in_stall  = (state_reg != tcmd_pkg::ST_LOAD);
    assign in_accept = in_valid && !in_stall;

    tcmd_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW),
        .VW    (VW)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (wr_addr),
        .wdata  (wr_data),
        .re0    (rd0_en),
        .raddr0 (rd0_addr),
        .rdata0 (q0),
        .re1    (rd1_en),
        .raddr1 (rd1_addr),
        .rdata1 (q1)
    );

    tcmd_relax #(
        .VW (VW)
    ) u_relax (
        .a     (a_reg),
        .b     (q0),
        .c     (q1),
        .ctl   (rctl),
        .value (rval)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        nodes_next    = nodes_reg;
        tri_next      = tri_reg;
        row_next      = row_reg;
        next_row_next = next_row_reg;
        len_next      = len_reg;
        round_next    = round_reg;
        changed_next  = changed_reg;
        b_addr_next   = b_addr_reg;
        c_addr_next   = c_addr_reg;
        a_next        = a_reg;
        scan_next     = scan_reg;
        scan_vld_next = 1'b0;
        max_next      = max_reg;
        code_next     = code_reg;
        mem_we        = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = in_value;
        rd0_en        = 1'b0;
        rd0_addr      = row_reg;
        rd1_en        = 1'b0;
        rd1_addr      = c_addr_reg;
        result_load   = 1'b0;
        changed_any   = changed_reg | rctl.changed;

        unique case (state_reg)
            tcmd_pkg::ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        // node count follows the smallest triangle that holds the entries
                        if (tri_reg == count_reg)
                        begin
                            tri_next   = tri_reg + CW'(nodes_reg);
                            nodes_next = nodes_reg + NW'(1);
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        max_next   = '0;
                        round_next = '0;
                        if (ovf_next)
                        begin
                            code_next  = tcmd_pkg::STATUS_OVERFLOW;
                            state_next = tcmd_pkg::ST_DONE;
                        end
                        else if (tri_next != count_next)
                        begin
                            code_next  = tcmd_pkg::STATUS_NOT_TRI;
                            state_next = tcmd_pkg::ST_DONE;
                        end
                        else
                        begin
                            code_next  = tcmd_pkg::STATUS_OK;
                            state_next = tcmd_pkg::ST_ROUND;
                        end
                    end
                end
            end

            tcmd_pkg::ST_ROUND:
            begin
                row_next     = '0;
                len_next     = nodes_reg - NW'(1);
                changed_next = 1'b0;
                if (nodes_reg < NW'(3))
                begin
                    scan_next  = '0;
                    state_next = tcmd_pkg::ST_MAX;
                end
                else
                begin
                    state_next = tcmd_pkg::ST_ROW;
                end
            end

            tcmd_pkg::ST_ROW:
            begin
                // row start is read only after every write of the previous row landed
                rd0_en        = 1'b1;
                rd0_addr      = row_reg;
                next_row_next = row_reg + AW'(len_reg);
                state_next    = tcmd_pkg::ST_FIRST;
            end

            tcmd_pkg::ST_FIRST:
            begin
                a_next      = q0;
                rd0_en      = 1'b1;
                rd0_addr    = row_reg + AW'(1);
                rd1_en      = 1'b1;
                rd1_addr    = next_row_reg;
                b_addr_next = row_reg + AW'(1);
                c_addr_next = next_row_reg;
                state_next  = tcmd_pkg::ST_EXEC;
            end

            tcmd_pkg::ST_EXEC:
            begin
                if (rctl.changed)
                begin
                    mem_we  = 1'b1;
                    wr_data = rval;
                    case (rctl.slot)
                        tcmd_pkg::SLOT_A:
                        begin
                            wr_addr = row_reg;
                            a_next  = rval;
                        end
                        tcmd_pkg::SLOT_B: wr_addr = b_addr_reg;
                        default:          wr_addr = c_addr_reg;
                    endcase
                end
                changed_next = changed_any;
                if (b_addr_reg + AW'(1) != next_row_reg)
                begin
                    // next triangle of the row touches other entries, so it overlaps
                    rd0_en      = 1'b1;
                    rd0_addr    = b_addr_reg + AW'(1);
                    rd1_en      = 1'b1;
                    rd1_addr    = c_addr_reg + AW'(1);
                    b_addr_next = b_addr_reg + AW'(1);
                    c_addr_next = c_addr_reg + AW'(1);
                end
                else
                begin
                    row_next = next_row_reg;
                    len_next = len_reg - NW'(1);
                    if (len_reg >= NW'(3))
                    begin
                        state_next = tcmd_pkg::ST_ROW;
                    end
                    else if (!changed_any ||
                             ((NW+1)'(round_reg) + (NW+1)'(2) >= (NW+1)'(nodes_reg)))
                    begin
                        scan_next  = '0;
                        state_next = tcmd_pkg::ST_MAX;
                    end
                    else
                    begin
                        round_next = round_reg + NW'(1);
                        state_next = tcmd_pkg::ST_ROUND;
                    end
                end
            end

            tcmd_pkg::ST_MAX:
            begin
                if (scan_reg < count_reg)
                begin
                    rd0_en        = 1'b1;
                    rd0_addr      = scan_reg[AW-1:0];
                    scan_next     = scan_reg + CW'(1);
                    scan_vld_next = 1'b1;
                end
                if (scan_vld_reg && (q0 > max_reg))
                begin
                    max_next = q0;
                end
                if ((scan_reg == count_reg) && !scan_vld_reg)
                begin
                    state_next = tcmd_pkg::ST_DONE;
                end
            end

            tcmd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_load = 1'b1;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    nodes_next  = NW'(2);
                    tri_next    = CW'(1);
                    state_next  = tcmd_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = tcmd_pkg::ST_LOAD;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || result_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcmd_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            nodes_reg     <= NW'(2);
            tri_reg       <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            nodes_reg     <= nodes_next;
            tri_reg       <= tri_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        next_row_reg <= next_row_next;
        len_reg      <= len_next;
        round_reg    <= round_next;
        changed_reg  <= changed_next;
        b_addr_reg   <= b_addr_next;
        c_addr_reg   <= c_addr_next;
        a_reg        <= a_next;
        scan_reg     <= scan_next;
        scan_vld_reg <= scan_vld_next;
        max_reg      <= max_next;
        code_reg     <= code_next;
        if (result_load)
        begin
            max_distance_reg <= out_wide[DW-1:0];
            status_reg       <= code_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign max_distance = max_distance_reg;
    assign status       = status_reg;

    `TCMD_ASSERT_IMP(a_err_zero, out_valid && (status != tcmd_pkg::STATUS_OK), max_distance == '0, "error result carries a nonzero distance")
    `TCMD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= DEPTH_C, "entry count beyond store depth")
    `TCMD_ASSERT_IMP(a_no_rw_overlap, (state_reg == tcmd_pkg::ST_EXEC) && mem_we && rd0_en, (wr_addr != rd0_addr) && (wr_addr != rd1_addr), "writeback collides with an overlapped read")
    `TCMD_ASSERT_NEXT(a_result_clears, result_load, (state_reg == tcmd_pkg::ST_LOAD) && (count_reg == '0) && !ovf_reg && out_valid, "result hand-off did not restart loading")

endmodule
